/* rtl/core/grid_q_table_update_defines.svh */
// Assertion macros for the bound checker in gqt_checker.sv.
// Each macro fires on the rising edge of clock and is held off during reset.
`ifndef GRID_Q_TABLE_UPDATE_DEFINES_SVH
`define GRID_Q_TABLE_UPDATE_DEFINES_SVH

// Same-cycle implication
`define GQT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define GQT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/gqt_pkg.sv */
package gqt_pkg;

   // Default grid geometry
   localparam int GRID_WIDTH_DEF   = 8;
   localparam int GRID_HEIGHT_DEF  = 6;
   localparam int ACTION_SLOTS_DEF = 5;

   // Fixed field widths
   localparam int VALUE_W = 32;
   localparam int RATE_W  = 16;
   localparam int MOVE_W  = 3;
   localparam int CSR_IDX_W = 8;

   // Register reset values (alpha 0.5, gamma 0.95)
   localparam logic [RATE_W-1:0] LEARN_RATE_RESET = 16'd32768;
   localparam logic [RATE_W-1:0] DISCOUNT_RESET   = 16'd62259;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT   = 8'd1;

   typedef struct packed {
      logic [3:0]                 cell_x;
      logic [2:0]                 cell_y;
      logic [MOVE_W-1:0]          move;
      logic signed [VALUE_W-1:0]  gain;
      logic [3:0]                 next_x;
      logic [2:0]                 next_y;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  new_value;
      logic [MOVE_W-1:0]          best_next_move;
      logic                       clipped;
   } rsp_type;

   // Status from the update arithmetic
   typedef struct packed {
      logic done;
      logic clipped;
   } upd_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_WRITE
   } state_type;

endpackage

/* rtl/core/gqt_ram.sv */
module gqt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 240
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/gqt_update.sv */
module gqt_update
   import gqt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [VALUE_W-1:0]  best,
   input  logic signed [VALUE_W-1:0]  old,
   input  logic signed [VALUE_W-1:0]  gain,
   input  logic [RATE_W-1:0]          learn_rate,
   input  logic [RATE_W-1:0]          discount,
   output logic signed [VALUE_W-1:0]  value,
   output upd_status_type             status
);

   // Stage 1: gamma * maxQ
   logic signed [48:0]         disc_prod_ff, disc_prod_in;
   logic signed [VALUE_W-1:0]  old1_ff, old1_in;
   logic signed [VALUE_W-1:0]  gain1_ff, gain1_in;
   logic                       v1_ff, v1_in;
   // Stage 2: target = gain + round(gamma * maxQ)
   logic signed [33:0]         target_ff, target_in;
   logic signed [VALUE_W-1:0]  old2_ff, old2_in;
   logic                       v2_ff, v2_in;
   // Stage 3: the two blend products
   logic signed [49:0]         keep_ff, keep_in;
   logic signed [50:0]         mix_ff, mix_in;
   logic                       v3_ff, v3_in;

   logic signed [48:0]         disc_rnd;
   logic signed [48:0]         disc_sh;
   logic [16:0]                inv_rate;
   logic signed [51:0]         blend;
   logic signed [51:0]         res;

   // Next values of the three stages
   always_comb begin
      disc_prod_in = $signed({1'b0, discount}) * best;
      old1_in      = old;
      gain1_in     = gain;
      v1_in        = start;

      disc_rnd  = disc_prod_ff + 49'sd32768;
      disc_sh   = disc_rnd >>> 16;
      target_in = $signed({{2{gain1_ff[VALUE_W-1]}}, gain1_ff}) + $signed(disc_sh[33:0]);
      old2_in   = old1_ff;
      v2_in     = v1_ff;

      inv_rate = 17'h10000 - {1'b0, learn_rate};
      keep_in  = $signed({1'b0, inv_rate}) * old2_ff;
      mix_in   = $signed({1'b0, learn_rate}) * target_ff;
      v3_in    = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      disc_prod_ff <= disc_prod_in;
      old1_ff      <= old1_in;
      gain1_ff     <= gain1_in;
      target_ff    <= target_in;
      old2_ff      <= old2_in;
      keep_ff      <= keep_in;
      mix_ff       <= mix_in;
   end

   // Sum, round to nearest (ties up) and saturate
   always_comb begin
      blend = 52'(keep_ff) + 52'(mix_ff) + 52'sd32768;
      res   = blend >>> 16;
      status.done = v3_ff;
      if (res > 52'sd2147483647) begin
         value          = 32'sh7FFFFFFF;
         status.clipped = 1'b1;
      end else if (res < -52'sd2147483648) begin
         value          = 32'sh80000000;
         status.clipped = 1'b1;
      end else begin
         value          = res[VALUE_W-1:0];
         status.clipped = 1'b0;
      end
   end

endmodule

/* rtl/core/grid_q_table_update.sv */
// Flow: a request is taken in idle; the scan then reads each next-cell slot and the target
// entry through the single read port, the three-stage update math runs, and the write-back
// stores the new value and issues the response. Only one transaction is in flight at a time.
// Reset: synchronous; the table is then zeroed one entry per cycle, covering all
// GRID_WIDTH * GRID_HEIGHT * ACTION_SLOTS entries (240 by default) before the first request.
// Registers return to alpha 0.5 and gamma 0.95 and can be written during the clear.
module grid_q_table_update
   import gqt_pkg::*;
#(
   parameter int GRID_WIDTH   = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT  = GRID_HEIGHT_DEF,
   parameter int ACTION_SLOTS = ACTION_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]    csr_data
);

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT * ACTION_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(ACTION_SLOTS + 3);

   state_type                  state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [IW-1:0]              iss_ff, iss_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IW-1:0]              rd_tag_ff, rd_tag_in;
   logic [AW-1:0]              nbase_ff, nbase_in;
   logic [AW-1:0]              tidx_ff, tidx_in;
   logic signed [VALUE_W-1:0]  gain_ff, gain_in;
   logic signed [VALUE_W-1:0]  best_ff, best_in;
   logic [MOVE_W-1:0]          best_idx_ff, best_idx_in;
   logic [RATE_W-1:0]          learn_rate_ff, learn_rate_in;
   logic [RATE_W-1:0]          discount_ff, discount_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       start;
   logic                       slot_free;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [VALUE_W-1:0]         wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [VALUE_W-1:0]         rd_data;
   logic signed [VALUE_W-1:0]  upd_value;
   upd_status_type             upd_status;

   // Q table
   gqt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Update arithmetic
   gqt_update u_update (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .best       (best_ff),
      .old        ($signed(rd_data)),
      .gain       (gain_ff),
      .learn_rate (learn_rate_ff),
      .discount   (discount_ff),
      .value      (upd_value),
      .status     (upd_status)
   );

   // Clamp both cells and the move, form table addresses
   always_comb begin
      int cx;
      int cy;
      int mv;
      int nx;
      int ny;
      cx = (int'(req_data.cell_x) >= GRID_WIDTH)   ? GRID_WIDTH - 1   : int'(req_data.cell_x);
      cy = (int'(req_data.cell_y) >= GRID_HEIGHT)  ? GRID_HEIGHT - 1  : int'(req_data.cell_y);
      mv = (int'(req_data.move)   >= ACTION_SLOTS) ? ACTION_SLOTS - 1 : int'(req_data.move);
      nx = (int'(req_data.next_x) >= GRID_WIDTH)   ? GRID_WIDTH - 1   : int'(req_data.next_x);
      ny = (int'(req_data.next_y) >= GRID_HEIGHT)  ? GRID_HEIGHT - 1  : int'(req_data.next_y);
      nbase_in = AW'((nx * GRID_HEIGHT + ny) * ACTION_SLOTS);
      tidx_in  = AW'((cx * GRID_HEIGHT + cy) * ACTION_SLOTS + mv);
   end

   // Running maximum over the next cell, first index wins ties
   assign start = rd_vld_ff && (rd_tag_ff == IW'(ACTION_SLOTS));

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (rd_vld_ff && (rd_tag_ff == '0)) begin
         best_in     = $signed(rd_data);
         best_idx_in = '0;
      end else if (rd_vld_ff && (rd_tag_ff < IW'(ACTION_SLOTS)) &&
                   ($signed(rd_data) > best_ff)) begin
         best_in     = $signed(rd_data);
         best_idx_in = MOVE_W'(rd_tag_ff);
      end
   end

   // Sequencer: clear, accept, scan, compute, write back
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      iss_in       = iss_ff;
      rd_tag_in    = iss_ff;
      rd_vld_in    = (state_ff == ST_SCAN);
      gain_in      = gain_ff;
      slot_free    = !rsp_valid_ff || !rsp_stall;
      accept       = 1'b0;
      req_stall    = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = tidx_ff;
      wr_data      = upd_value;
      rd_en        = 1'b0;
      rd_addr      = (iss_ff < IW'(ACTION_SLOTS)) ? AW'(nbase_ff + AW'(iss_ff)) : tidx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            if (req_valid) begin
               gain_in  = req_data.gain;
               iss_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            iss_in = iss_ff + 1'b1;
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (upd_status.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               wr_en                      = 1'b1;
               rsp_valid_in               = 1'b1;
               rsp_data_in.new_value      = upd_value;
               rsp_data_in.best_next_move = best_idx_ff;
               rsp_data_in.clipped        = upd_status.clipped;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      learn_rate_in = learn_rate_ff;
      discount_in   = discount_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEARN_RATE: learn_rate_in = csr_data;
            CSR_DISCOUNT:   discount_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         iss_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rd_tag_ff     <= '0;
         learn_rate_ff <= LEARN_RATE_RESET;
         discount_ff   <= DISCOUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         iss_ff        <= iss_in;
         rd_vld_ff     <= rd_vld_in;
         rd_tag_ff     <= rd_tag_in;
         learn_rate_ff <= learn_rate_in;
         discount_ff   <= discount_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         nbase_ff <= nbase_in;
         tidx_ff  <= tidx_in;
      end
      gain_ff     <= gain_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/gqt_checker.sv */
`include "grid_q_table_update_defines.svh"

module gqt_checker
   import gqt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_take;
   logic rsp_held;
   logic rsp_at_limit;

   assign req_take     = req_valid && !req_stall;
   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_at_limit = (rsp_data.new_value == 32'sh7FFFFFFF) ||
                         (rsp_data.new_value == 32'sh80000000);

   // One transaction in flight: the request side closes right after an accept
   `GQT_ASSERT_NEXT(a_one_in_flight, req_take, req_stall, "second request taken while busy")

   // A response never appears the cycle after a request is taken
   `GQT_ASSERT_NEXT(a_no_early_rsp, req_take, !$rose(rsp_valid), "response too early")

   // A stalled response holds
   `GQT_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "stalled response changed")

   // Saturation flag only with a limit value
   `GQT_ASSERT_NOW(a_clip_limit, rsp_valid && rsp_data.clipped, rsp_at_limit, "clip without limit")

endmodule

bind grid_q_table_update gqt_checker u_gqt_checker (.*);

/* sim/grid_q_table_update_checker.sv */
module grid_q_table_update_checker
   import gqt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = GRID_WIDTH_DEF * GRID_HEIGHT_DEF * ACTION_SLOTS_DEF;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;
   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the Q table and the two rate registers
   logic signed [VALUE_W-1:0] q_shadow [TABLE_DEPTH];
   logic [RATE_W-1:0]         alpha_reg;
   logic [RATE_W-1:0]         gamma_reg;
   rsp_type                   expected_updates[$];
   int                        fails;

   // Nearest Q16.16 rounding, ties toward +inf
   function automatic longint round_q16(input longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic int clamp_to(input int v, input int lim);
      return (v >= lim) ? lim - 1 : v;
   endfunction

   // One Q-learning step against the shadow table; returns the expected response
   function automatic rsp_type q_update(input req_type t);
      int      cx, cy, mv, nx, ny, nbase, slot;
      longint  best, old_q, target, blend, res;
      rsp_type r;
      cx    = clamp_to(int'(t.cell_x), GRID_WIDTH_DEF);
      cy    = clamp_to(int'(t.cell_y), GRID_HEIGHT_DEF);
      mv    = clamp_to(int'(t.move), ACTION_SLOTS_DEF);
      nx    = clamp_to(int'(t.next_x), GRID_WIDTH_DEF);
      ny    = clamp_to(int'(t.next_y), GRID_HEIGHT_DEF);
      nbase = (nx * GRID_HEIGHT_DEF + ny) * ACTION_SLOTS_DEF;
      slot  = (cx * GRID_HEIGHT_DEF + cy) * ACTION_SLOTS_DEF + mv;

      // greedy scan of the next cell, first index wins a tie
      best = q_shadow[nbase];
      r.best_next_move = '0;
      for (int a = 1; a < ACTION_SLOTS_DEF; a++) begin
         if (q_shadow[nbase + a] > best) begin
            best = q_shadow[nbase + a];
            r.best_next_move = MOVE_W'(a);
         end
      end

      old_q  = q_shadow[slot];
      target = longint'(t.gain) + round_q16(longint'(gamma_reg) * best);
      blend  = (64'sd65536 - longint'(alpha_reg)) * old_q + longint'(alpha_reg) * target;
      res    = round_q16(blend);

      r.clipped = 1'b0;
      if (res > VALUE_MAX) begin
         res = VALUE_MAX;
         r.clipped = 1'b1;
      end else if (res < VALUE_MIN) begin
         res = VALUE_MIN;
         r.clipped = 1'b1;
      end
      r.new_value    = res[VALUE_W-1:0];
      q_shadow[slot] = res[VALUE_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) q_shadow[i] = '0;
         alpha_reg = LEARN_RATE_RESET;
         gamma_reg = DISCOUNT_RESET;
         expected_updates.delete();
         fails = 0;
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LEARN_RATE) alpha_reg = csr_data;
            else if (csr_index == CSR_DISCOUNT) gamma_reg = csr_data;
         end

         // response side: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               if (fails < REPORT_LIMIT)
                  $display("%0t: unexpected response new_value %h best_next_move %0d clipped %0b",
                     $realtime, rsp_data.new_value, rsp_data.best_next_move, rsp_data.clipped);
               fails++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_data.new_value !== want.new_value ||
                   rsp_data.best_next_move !== want.best_next_move ||
                   rsp_data.clipped !== want.clipped) begin
                  if (fails < REPORT_LIMIT) begin
                     $write("%0t: mismatch new_value exp %h got %h, ",
                        $realtime, want.new_value, rsp_data.new_value);
                     $display("best_next_move exp %0d got %0d, clipped exp %0b got %0b",
                        want.best_next_move, rsp_data.best_next_move,
                        want.clipped, rsp_data.clipped);
                  end
                  fails++;
               end
            end
         end

         // request side: predict at acceptance
         if (req_valid && !req_stall)
            expected_updates = {expected_updates, q_update(req_data)};
      end
      fail_count    <= fails;
      pending_count <= expected_updates.size();
   end

endmodule

/* sim/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gqt_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 135;
   localparam int PHASE_COUNT   = 7;
   localparam int SETTLE_CYCLES = 2 * ACTION_SLOTS_DEF + 8;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_DISCOUNT + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX   = '1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RATE_W-1:0]    csr_data  = '0;

   int fails;
   int pending;
   int cycle_count = 0;
   bit calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   grid_q_table_update DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   grid_q_table_update_checker q_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count    (fails),
      .pending_count (pending)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Response backpressure in random bursts
   always begin
      @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 4)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type mk_update(input logic [3:0] cx, input logic [2:0] cy,
                                         input logic [2:0] mv, input logic [31:0] g,
                                         input logic [3:0] nx, input logic [2:0] ny);
      req_type t;
      t.cell_x = cx;
      t.cell_y = cy;
      t.move   = mv;
      t.gain   = g;
      t.next_x = nx;
      t.next_y = ny;
      return t;
   endfunction

   // Mostly legal moves, many on a small patch so values build up; some raw noise
   function automatic req_type rand_update();
      req_type t;
      int      kind;
      int      span;
      kind = $urandom_range(0, 9);
      span = (kind < 5) ? 2 : GRID_WIDTH_DEF - 1;
      if (kind == 0) begin
         t.cell_x = 4'($urandom);
         t.cell_y = 3'($urandom);
         t.move   = 3'($urandom);
         t.gain   = $urandom;
         t.next_x = 4'($urandom);
         t.next_y = 3'($urandom);
      end else begin
         t.cell_x = 4'($urandom_range(0, span));
         t.cell_y = 3'($urandom_range(0, (kind < 5) ? 1 : GRID_HEIGHT_DEF - 1));
         t.move   = 3'($urandom_range(0, ACTION_SLOTS_DEF - 1));
         case ($urandom_range(0, 7))
            0:       t.gain = 32'h7FFF_FFFF;
            1:       t.gain = 32'h8000_0000;
            2:       t.gain = $urandom;
            default: t.gain = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         endcase
         if ($urandom_range(0, 3) == 0) begin
            t.next_x = t.cell_x;
            t.next_y = t.cell_y;
         end else begin
            t.next_x = 4'($urandom_range(0, span));
            t.next_y = 3'($urandom_range(0, (kind < 5) ? 1 : GRID_HEIGHT_DEF - 1));
         end
      end
      return t;
   endfunction

   // Present one transaction, with an optional leading gap
   task automatic send_update(input req_type t);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off until every response is back and the write-back has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stray write to an unused index, then both rates
   task automatic program_rates(input logic [RATE_W-1:0] lr, input logic [RATE_W-1:0] disc);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX));
      csr_data  <= RATE_W'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LEARN_RATE;
      csr_data  <= lr;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DISCOUNT;
      csr_data  <= disc;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_updates();
      // repeated top reward on a self loop saturates high
      repeat (4) send_update(mk_update(0, 0, 0, 32'h7FFF_FFFF, 0, 0));
      // all-ones and just-past-edge coordinates, move past the last slot
      send_update(mk_update(15, 7, 7, 32'h8000_0000, 15, 7));
      send_update(mk_update(8, 6, 5, 32'h8000_0000, 8, 6));
      // fill a cell with negatives, then drive one slot below the floor
      for (int m = 0; m < ACTION_SLOTS_DEF; m++)
         send_update(mk_update(1, 1, 3'(m), 32'h8000_0000, 2, 2));
      repeat (4) send_update(mk_update(1, 1, 2, 32'h8000_0000, 1, 1));
      // small rewards against saturated, negative and all-zero next cells
      send_update(mk_update(3, 2, 1, 32'h0000_0001, 0, 0));
      send_update(mk_update(7, 5, 3, 32'h0000_0000, 1, 1));
      send_update(mk_update(2, 4, 2, 32'hFFFF_FFFF, 6, 3));
      send_update(mk_update(9, 1, 4, 32'h0001_0000, 0, 0));
   endtask

   initial begin
      logic [RATE_W-1:0] lr;
      logic [RATE_W-1:0] disc;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset rates first
      directed_updates();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin lr = '1;                disc = '1;             end
            1:       begin lr = '0;                disc = '0;             end
            2:       begin lr = 16'd1;             disc = '1;             end
            3:       begin lr = '1;                disc = '0;             end
            4, 5:    begin lr = RATE_W'($urandom); disc = RATE_W'($urandom); end
            default: begin lr = LEARN_RATE_RESET;  disc = DISCOUNT_RESET; end
         endcase
         wait_idle();
         program_rates(lr, disc);
         // final phase runs with no gaps on either side
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         repeat (PHASE_ITEMS) send_update(rand_update());
      end

      wait_idle();
      if (fails == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
